FILE: hw/rtl/pd5fp_pkg.sv
package pd5fp_pkg;

   localparam int FIELD_COUNT = 40;
   localparam int TABLE_DEPTH = 128;

   localparam logic [7:0] SYNC_RESET       = 8'h7d;
   localparam logic [6:0] POS_HUNT         = 7'd0;
   localparam logic [6:0] POS_FIRST_DATA   = 7'd1;
   localparam logic [6:0] POS_CHK_LOW      = 7'd86;
   localparam logic [6:0] POS_CHK_HIGH     = 7'd87;
   localparam logic [5:0] STATUS_INDEX     = 6'd40;

   localparam logic [2:0] FIELD_SIZE [0:FIELD_COUNT-1] = '{
      3'd1, 3'd1, 3'd2, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2,
      3'd2, 3'd2, 3'd2, 3'd2,
      3'd1,
      3'd2, 3'd2, 3'd2, 3'd2,
      3'd2, 3'd2,
      3'd1,
      3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd1, 3'd2,
      3'd2, 3'd2, 3'd2,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
   };

   localparam logic FIELD_SIGNED [0:FIELD_COUNT-1] = '{
      1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b1, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0,
      1'b0,
      1'b1, 1'b1, 1'b1, 1'b1,
      1'b1, 1'b1,
      1'b0,
      1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b1,
      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
   };

   typedef struct packed {
      logic [5:0] index;
      logic [1:0] offset;
      logic       last;
      logic       sext;
   } pos_info_type;

   typedef pos_info_type [TABLE_DEPTH-1:0] pos_table_type;

   typedef struct packed {
      logic        emit;
      logic [5:0]  field_index;
      logic [31:0] field_value;
      logic        checksum_ok;
      logic        frame_last;
   } result_type;

   function automatic pos_table_type build_pos_table();
      pos_table_type tbl;
      int            start;
      tbl   = '0;
      start = 0;
      for (int f = 0; f < FIELD_COUNT; f++) begin
         for (int b = 0; b < int'(FIELD_SIZE[f]); b++) begin
            tbl[start + b].index  = 6'(f);
            tbl[start + b].offset = 2'(b);
            tbl[start + b].last   = (b == int'(FIELD_SIZE[f]) - 1);
            tbl[start + b].sext   = FIELD_SIGNED[f] && (FIELD_SIZE[f] == 3'd2);
         end
         start += int'(FIELD_SIZE[f]);
      end
      return tbl;
   endfunction

   localparam pos_table_type POS_TABLE = build_pos_table();

endpackage

FILE: hw/rtl/pd5fp_in_stage.sv
module pd5fp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       can_take,
   output logic       advance,
   output logic [7:0] rx_byte
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   always_comb begin
      advance   = valid_ff && can_take;
      req_stall = valid_ff && !advance;
      accept    = req_valid && !req_stall;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      rx_byte = byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end
endmodule

FILE: hw/rtl/pd5fp_parser.sv
module pd5fp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           rx_byte,
   input  logic                 csr_write,
   input  logic [7:0]           csr_data,
   output pd5fp_pkg::result_type result
);
   import pd5fp_pkg::*;

   logic [7:0]   sync_ff;
   logic [6:0]   pos_ff;
   logic [6:0]   pos_in;
   logic [31:0]  acc_ff;
   logic [31:0]  acc_in;
   logic [15:0]  sum_ff;
   logic [15:0]  sum_in;
   pos_info_type info;
   logic [15:0]  chk;

   always_comb begin
      info   = POS_TABLE[pos_ff];
      chk    = {rx_byte, acc_ff[7:0]};
      pos_in = pos_ff;
      acc_in = acc_ff;
      sum_in = sum_ff;
      result = '0;
      if (pos_ff == POS_HUNT) begin
         if (rx_byte == sync_ff) begin
            pos_in             = POS_FIRST_DATA;
            acc_in             = {24'd0, rx_byte};
            sum_in             = {8'd0, rx_byte};
            result.emit        = 1'b1;
            result.field_value = {24'd0, rx_byte};
         end
      end else if (pos_ff < POS_CHK_LOW) begin
         if (info.offset == 2'd0) begin
            acc_in = {24'd0, rx_byte};
         end else begin
            acc_in = acc_ff | ({24'd0, rx_byte} << {info.offset, 3'b000});
         end
         sum_in             = sum_ff + {8'd0, rx_byte};
         pos_in             = pos_ff + 7'd1;
         result.emit        = info.last;
         result.field_index = info.index;
         if (info.sext && acc_in[15]) begin
            result.field_value = {16'hffff, acc_in[15:0]};
         end else begin
            result.field_value = acc_in;
         end
      end else if (pos_ff == POS_CHK_LOW) begin
         acc_in = {24'd0, rx_byte};
         pos_in = POS_CHK_HIGH;
      end else begin
         acc_in             = {16'd0, chk};
         pos_in             = POS_HUNT;
         result.emit        = 1'b1;
         result.field_index = STATUS_INDEX;
         result.field_value = {16'd0, chk};
         result.checksum_ok = (chk == sum_ff);
         result.frame_last  = 1'b1;
      end
      if (!advance) begin
         result.emit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
         pos_ff  <= POS_HUNT;
         acc_ff  <= '0;
         sum_ff  <= '0;
      end else begin
         if (csr_write) begin
            sync_ff <= csr_data;
         end
         if (advance) begin
            pos_ff <= pos_in;
            acc_ff <= acc_in;
            sum_ff <= sum_in;
         end
      end
   end
endmodule

FILE: hw/rtl/pd5fp_out_reg.sv
module pd5fp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  pd5fp_pkg::result_type result,
   output logic                  can_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [5:0]            rsp_field_index,
   output logic signed [31:0]    rsp_field_value,
   output logic                  rsp_checksum_ok,
   output logic                  rsp_frame_last
);
   import pd5fp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   always_comb begin
      can_take = !valid_ff || !rsp_stall;
      if (result.emit) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
      rsp_valid       = valid_ff;
      rsp_field_index = data_ff.field_index;
      rsp_field_value = $signed(data_ff.field_value);
      rsp_checksum_ok = data_ff.checksum_ok;
      rsp_frame_last  = data_ff.frame_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.emit) begin
         data_ff <= result;
      end
   end
endmodule

FILE: hw/rtl/dvl_pd5_frame_parser.sv
// A result passes from the input register through the result register to the outputs.
// Throughput: one byte per cycle while rsp_stall is low; a byte ending no field gives no result.
// Frame position, field assembly and checksum sum advance in one pass from the input register.
// Reset (synchronous, active high): hunting for sync, sync byte 0x7d, both registers empty.
module dvl_pd5_frame_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_field_index,
   output logic signed [31:0] rsp_field_value,
   output logic               rsp_checksum_ok,
   output logic               rsp_frame_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_sync_byte
);
   import pd5fp_pkg::*;

   logic       can_take;
   logic       advance;
   logic [7:0] rx_byte;
   result_type result;

   assign csr_ready = 1'b1;

   pd5fp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .can_take    (can_take),
      .advance     (advance),
      .rx_byte     (rx_byte)
   );

   pd5fp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rx_byte   (rx_byte),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_sync_byte),
      .result    (result)
   );

   pd5fp_out_reg u_out_reg (
      .clock           (clock),
      .reset           (reset),
      .result          (result),
      .can_take        (can_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_frame_last  (rsp_frame_last)
   );
endmodule

FILE: verif/dvl_pd5_frame_parser_tb.sv
`timescale 1ns / 100ps

module dvl_pd5_frame_parser_tb;

   localparam int NUM_FIELDS     = 40;
   localparam int FRAME_DATA_END = 86;
   localparam int SETTLE_CYCLES  = 4;
   localparam int IDLE_LIMIT     = 1000;
   localparam int PHASE_ITEMS    = 130;

   localparam int FLD_BYTES [NUM_FIELDS] = '{
      1, 1, 2, 1,
      2, 2, 2, 2,
      2, 2, 2, 2,
      1,
      2, 2, 2, 2,
      2, 2,
      1,
      1, 1, 1, 1,
      2, 2, 2, 1, 2,
      2, 2, 2,
      4, 4, 4, 4, 4, 4, 4, 4
   };

   localparam bit FLD_SIGNED [NUM_FIELDS] = '{
      0, 0, 0, 0,
      1, 1, 1, 1,
      0, 0, 0, 0,
      0,
      1, 1, 1, 1,
      1, 1,
      0,
      0, 0, 0, 0,
      0, 0, 0, 0, 0,
      1, 1, 1,
      1, 1, 1, 1, 1, 1, 1, 1
   };

   localparam logic [5:0] FLD_ID        = 6'd0;
   localparam logic [5:0] FLD_STRUCTURE = 6'd1;
   localparam logic [5:0] FLD_VEL_BTM0  = 6'd4;
   localparam logic [5:0] FLD_VEL_BTM1  = 6'd5;
   localparam logic [5:0] FLD_DMG0      = 6'd32;
   localparam logic [5:0] FLD_DMG1      = 6'd33;

   typedef struct packed {
      logic [5:0]  fidx;
      logic [31:0] fval;
      logic        csum_ok;
      logic        is_last;
   } parsed_field_type;

   localparam parsed_field_type NO_FIELD = '0;

   typedef struct {
      logic [7:0]       rx;
      int               reps;
      bit               typed;
      parsed_field_type want;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [5:0]         rsp_field_index;
   logic signed [31:0] rsp_field_value;
   logic               rsp_checksum_ok;
   logic               rsp_frame_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_sync_byte = 8'h00;

   logic [7:0]  sync_val = pd5fp_pkg::SYNC_RESET;
   logic [6:0]  frame_pos = '0;
   logic [31:0] field_acc = '0;
   logic [15:0] frame_sum = '0;

   parsed_field_type pending_fields [$];
   script_row_type   script [23];
   int               fail_count = 0;
   int               parsed_count = 0;
   int               burst_left = 0;
   int               idle_cycles = 0;
   int               stall_left = 0;
   int               stall_mode = 0;
   logic [7:0]       cycle_count = '0;

   dvl_pd5_frame_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_frame_last  (rsp_frame_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_sync_byte   (csr_sync_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit parse_byte(input logic [7:0] b, output parsed_field_type r);
      int          start;
      int          f;
      int          off;
      logic [31:0] v;
      r = NO_FIELD;
      if (frame_pos == 0) begin
         if (b != sync_val)
            return 1'b0;
         frame_sum = 16'(b);
         field_acc = 32'(b);
         frame_pos = 7'd1;
         r.fidx = FLD_ID;
         r.fval = 32'(b);
         return 1'b1;
      end
      if (frame_pos < FRAME_DATA_END) begin
         start = 0;
         f = 0;
         while (f < NUM_FIELDS - 1 && start + FLD_BYTES[f] <= int'(frame_pos)) begin
            start += FLD_BYTES[f];
            f++;
         end
         off = int'(frame_pos) - start;
         if (off == 0)
            field_acc = 32'(b);
         else
            field_acc = field_acc | (32'(b) << (8 * off));
         frame_sum = frame_sum + 16'(b);
         frame_pos = frame_pos + 7'd1;
         if (off + 1 == FLD_BYTES[f]) begin
            v = field_acc;
            if (FLD_BYTES[f] == 2 && FLD_SIGNED[f] && v[15])
               v[31:16] = 16'hFFFF;
            r.fidx = 6'(f);
            r.fval = v;
            return 1'b1;
         end
         return 1'b0;
      end
      if (frame_pos == FRAME_DATA_END) begin
         field_acc = 32'(b);
         frame_pos = frame_pos + 7'd1;
         return 1'b0;
      end
      field_acc = {16'h0000, b, field_acc[7:0]};
      r.fidx    = pd5fp_pkg::STATUS_INDEX;
      r.fval    = field_acc;
      r.csum_ok = (field_acc[15:0] == frame_sum);
      r.is_last = 1'b1;
      frame_pos = '0;
      return 1'b1;
   endfunction

   task automatic feed(input logic [7:0] b, input bit typed = 1'b0,
                       input parsed_field_type want = NO_FIELD);
      parsed_field_type got;
      bit               hit;
      int               gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (frame_pos != 0 || b == sync_val)
         parsed_count++;
      hit = parse_byte(b, got);
      if (typed)
         pending_fields.push_back(want);
      else if (hit)
         pending_fields.push_back(got);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_fields.size() != 0) @(posedge clock);
   endtask

   task automatic write_sync(input logic [7:0] v);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_sync_byte <= v;
      csr_valid     <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sync_val = v;
   endtask

   function automatic logic [7:0] extreme_byte();
      case ($urandom_range(0, 3))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         2: begin
            return 8'h7F;
         end
         default: begin
            return 8'h80;
         end
      endcase
   endfunction

   task automatic send_frame(input bit good_sum);
      logic [15:0] sum;
      logic [15:0] chk;
      logic [7:0]  b;
      logic [7:0]  fill;
      int          style;
      style = $urandom_range(0, 3);
      fill  = 8'($urandom);
      sum   = 16'(sync_val);
      feed(sync_val);
      for (int i = 1; i < FRAME_DATA_END; i++) begin
         case (style)
            0, 1: begin
               b = 8'($urandom);
            end
            2: begin
               b = extreme_byte();
            end
            default: begin
               b = fill;
            end
         endcase
         sum = sum + 16'(b);
         feed(b);
      end
      if (good_sum)
         chk = sum;
      else
         case ($urandom_range(0, 3))
            0: begin
               chk = ~sum;
            end
            1: begin
               chk = 16'h0000;
            end
            2: begin
               chk = 16'hFFFF;
            end
            default: begin
               chk = 16'($urandom);
            end
         endcase
      feed(chk[7:0]);
      feed(chk[15:8]);
   endtask

   task automatic send_broken_frame();
      int cut;
      cut = $urandom_range(0, FRAME_DATA_END - 2);
      feed(sync_val);
      repeat (cut) feed(8'($urandom));
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 8'd1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(32, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= (cycle_count[2:1] == 2'b11);
         end
      endcase
   end

   always @(posedge clock) begin : check_results
      parsed_field_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_fields.size() == 0) begin
            $error("unexpected result: field_index %0d field_value %h",
                   rsp_field_index, rsp_field_value);
            fail_count++;
         end else begin
            head = pending_fields.pop_front();
            if (rsp_field_index !== head.fidx) begin
               $error("field_index: expected %0d, got %0d", head.fidx, rsp_field_index);
               fail_count++;
            end
            if (rsp_field_value !== head.fval) begin
               $error("field_value: expected %h, got %h", head.fval, rsp_field_value);
               fail_count++;
            end
            if (rsp_checksum_ok !== head.csum_ok) begin
               $error("checksum_ok: expected %b, got %b", head.csum_ok, rsp_checksum_ok);
               fail_count++;
            end
            if (rsp_frame_last !== head.is_last) begin
               $error("frame_last: expected %b, got %b", head.is_last, rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int          pick;
      int          phase_start;
      logic [7:0]  next_sync;
      script = '{
         '{8'h00, 1,  1'b0, NO_FIELD},
         '{8'hFF, 1,  1'b0, NO_FIELD},
         '{8'h7C, 1,  1'b0, NO_FIELD},
         '{8'h7D, 1,  1'b1, '{FLD_ID, 32'h0000007D, 1'b0, 1'b0}},
         '{8'h7D, 1,  1'b1, '{FLD_STRUCTURE, 32'h0000007D, 1'b0, 1'b0}},
         '{8'hFF, 2,  1'b0, NO_FIELD},
         '{8'h00, 1,  1'b0, NO_FIELD},
         '{8'h00, 1,  1'b0, NO_FIELD},
         '{8'h80, 1,  1'b1, '{FLD_VEL_BTM0, 32'hFFFF8000, 1'b0, 1'b0}},
         '{8'hFF, 1,  1'b0, NO_FIELD},
         '{8'h7F, 1,  1'b1, '{FLD_VEL_BTM1, 32'h00007FFF, 1'b0, 1'b0}},
         '{8'hA5, 45, 1'b0, NO_FIELD},
         '{8'h00, 3,  1'b0, NO_FIELD},
         '{8'h80, 1,  1'b1, '{FLD_DMG0, 32'h80000000, 1'b0, 1'b0}},
         '{8'hFF, 3,  1'b0, NO_FIELD},
         '{8'h7F, 1,  1'b1, '{FLD_DMG1, 32'h7FFFFFFF, 1'b0, 1'b0}},
         '{8'h5A, 24, 1'b0, NO_FIELD},
         '{8'h00, 1,  1'b0, NO_FIELD},
         '{8'h00, 1,  1'b1, '{pd5fp_pkg::STATUS_INDEX, 32'h00000000, 1'b0, 1'b1}},
         '{8'h7D, 1,  1'b1, '{FLD_ID, 32'h0000007D, 1'b0, 1'b0}},
         '{8'h00, 85, 1'b0, NO_FIELD},
         '{8'h7D, 1,  1'b0, NO_FIELD},
         '{8'h00, 1,  1'b1, '{pd5fp_pkg::STATUS_INDEX, 32'h0000007D, 1'b1, 1'b1}}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         for (int k = 0; k < script[r].reps; k++)
            feed(script[r].rx, script[r].typed && (k == script[r].reps - 1), script[r].want);
      end

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               next_sync = sync_val;
            end
            1: begin
               next_sync = 8'h00;
            end
            2: begin
               next_sync = 8'hFF;
            end
            3: begin
               next_sync = 8'($urandom);
            end
            default: begin
               next_sync = pd5fp_pkg::SYNC_RESET;
            end
         endcase
         if (ph > 0)
            write_sync(next_sync);
         phase_start = parsed_count;
         while (parsed_count - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               hold_until_drained();
            else if (pick < 15)
               send_frame($urandom_range(0, 3) != 0);
            else if (pick < 18)
               repeat ($urandom_range(1, 6)) feed(8'($urandom));
            else
               send_broken_frame();
         end
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_fields.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
